@@ hdl/sckv_pkg.sv @@
package sckv_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_W     = 9;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CMD_GET    = 2'd0,
    CMD_PUT    = 2'd1,
    CMD_REMOVE = 2'd2
  } command_t;

  typedef enum logic [1:0] {
    STAT_OK           = 2'd0,
    STAT_NOT_FOUND    = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2,
    STAT_FULL         = 2'd3
  } status_t;

  typedef struct packed {
    command_t           command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]         new_value;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [7:0]         stored_value;
    logic [COUNT_W-1:0] entry_count;
  } response_t;

  typedef struct packed {
    logic [15:0] x;
    logic [7:0]  y;
    logic [15:0] z;
    logic [7:0]  value;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_SRCH_CMP,
    S_HIT_CMP,
    S_DECIDE,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    srch_mid;
    logic    srch_lo;
    logic    cmp_step;
    logic    hit_chk;
    logic    res_load;
    status_t res_status;
    logic    res_use_value;
    logic    overwrite;
    logic    shift_up_init;
    logic    shift_dn_init;
    logic    shift_up;
    logic    shift_dn;
    logic    place;
    logic    shrink;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    command_t command;
    logic     cmd_known;
    logic     in_range;
    logic     lo_lt_hi;
    logic     lo_lt_occ;
    logic     hit;
    logic     full;
    logic     up_more;
    logic     dn_more;
    logic     out_busy;
  } dp_status_t;

endpackage

@@ hdl/sckv_ctrl.sv @@
module sckv_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  sckv_pkg::dp_status_t sts,
  output sckv_pkg::dp_cmd_t    cmd
);
  import sckv_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.cmd_known || (sts.command == CMD_PUT && !sts.in_range)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (sts.lo_lt_hi) begin
          state_next = S_SRCH_CMP;
        end else if (sts.lo_lt_occ) begin
          state_next = S_HIT_CMP;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_SRCH_CMP: state_next = S_SRCH;
      S_HIT_CMP:  state_next = S_DECIDE;
      S_DECIDE: begin
        if (sts.command == CMD_PUT && !sts.hit && !sts.full) begin
          state_next = S_SHIFT_UP;
        end else if (sts.command == CMD_REMOVE && sts.hit) begin
          state_next = S_SHIFT_DN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (!sts.up_more) state_next = S_PLACE;
      end
      S_PLACE: state_next = S_DONE;
      S_SHIFT_DN: begin
        if (!sts.dn_more) state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.accept = req_valid;
      end
      S_CHECK: begin
        if (!sts.cmd_known) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_NOT_FOUND;
        end else if (sts.command == CMD_PUT && !sts.in_range) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = STAT_OUT_OF_RANGE;
        end
      end
      S_SRCH: begin
        if (sts.lo_lt_hi) begin
          cmd.srch_mid = 1'b1;
        end else if (sts.lo_lt_occ) begin
          cmd.srch_lo = 1'b1;
        end
      end
      S_SRCH_CMP: cmd.cmp_step = 1'b1;
      S_HIT_CMP:  cmd.hit_chk  = 1'b1;
      S_DECIDE: begin
        cmd.res_load   = 1'b1;
        cmd.res_status = STAT_NOT_FOUND;
        case (sts.command)
          CMD_GET: begin
            if (sts.hit) begin
              cmd.res_status    = STAT_OK;
              cmd.res_use_value = 1'b1;
            end
          end
          CMD_PUT: begin
            if (sts.hit) begin
              cmd.res_status = STAT_OK;
              cmd.overwrite  = 1'b1;
            end else if (sts.full) begin
              cmd.res_status = STAT_FULL;
            end else begin
              cmd.res_status    = STAT_OK;
              cmd.shift_up_init = 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (sts.hit) begin
              cmd.res_status    = STAT_OK;
              cmd.shift_dn_init = 1'b1;
            end
          end
          default: cmd.res_status = STAT_NOT_FOUND;
        endcase
      end
      S_SHIFT_UP: cmd.shift_up = sts.up_more;
      S_PLACE:    cmd.place    = 1'b1;
      S_SHIFT_DN: begin
        cmd.shift_dn = sts.dn_more;
        cmd.shrink   = !sts.dn_more;
      end
      S_DONE: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/sckv_dp.sv @@
module sckv_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sckv_pkg::request_t   req,
  input  logic                 rsp_stall,
  output logic                 rsp_valid,
  output sckv_pkg::response_t  rsp,
  input  sckv_pkg::dp_cmd_t    cmd,
  output sckv_pkg::dp_status_t sts
);
  import sckv_pkg::*;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata;

  request_t          cur;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  ptr;
  logic [CNT_W-1:0]  occupancy;
  logic              hit;
  logic [7:0]        found_value;
  status_t           res_status;
  logic [7:0]        res_value;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  logic [CNT_W-1:0]   mid;
  logic [CNT_W-1:0]   ptr_dec;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  entry_t             wr_data;
  entry_t             new_entry;
  logic signed [31:0] sx;
  logic signed [31:0] sy;
  logic signed [31:0] sz;
  logic               key_gt;
  logic               key_eq;

  assign mid     = lo + ((hi - lo) >> 1);
  assign ptr_dec = ptr - CNT_W'(1);

  // Stored coordinates widened back to the request's signed 32-bit form.
  assign sx = {{16{rdata.x[15]}}, rdata.x};
  assign sy = {24'd0, rdata.y};
  assign sz = {{16{rdata.z[15]}}, rdata.z};

  assign key_eq = ($signed(cur.pos_x) == sx) && ($signed(cur.pos_y) == sy) &&
                  ($signed(cur.pos_z) == sz);
  assign key_gt = ($signed(cur.pos_x) > sx) ||
                  (($signed(cur.pos_x) == sx) &&
                   (($signed(cur.pos_y) > sy) ||
                    (($signed(cur.pos_y) == sy) && ($signed(cur.pos_z) > sz))));

  assign new_entry = '{x: cur.pos_x[15:0], y: cur.pos_y[7:0], z: cur.pos_z[15:0],
                       value: cur.new_value};

  always_comb begin
    rd_addr = '0;
    if (cmd.srch_mid) rd_addr = mid[ADDR_W-1:0];
    if (cmd.srch_lo)  rd_addr = lo[ADDR_W-1:0];
    if (cmd.shift_up) rd_addr = ptr_dec[ADDR_W-1:0];
    if (cmd.shift_dn) rd_addr = ptr[ADDR_W-1:0];
  end

  // Drain a pending shift copy first; overwrite and place never overlap it.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rdata;
    if (pend) begin
      wr_en = 1'b1;
    end else if (cmd.overwrite || cmd.place) begin
      wr_en   = 1'b1;
      wr_addr = lo[ADDR_W-1:0];
      wr_data = new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      rsp_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cmd.place)       occupancy <= occupancy + CNT_W'(1);
      else if (cmd.shrink) occupancy <= occupancy - CNT_W'(1);
      if (cmd.out_load)       rsp_valid <= 1'b1;
      else if (!rsp_stall)    rsp_valid <= 1'b0;
      pend <= cmd.shift_up || cmd.shift_dn;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur <= req;
      lo  <= '0;
      hi  <= occupancy;
      hit <= 1'b0;
    end
    if (cmd.cmp_step) begin
      if (key_gt) lo <= mid + CNT_W'(1);
      else        hi <= mid;
    end
    if (cmd.hit_chk) begin
      hit         <= key_eq;
      found_value <= rdata.value;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_use_value ? found_value : 8'd0;
    end
    if (cmd.shift_up_init) ptr <= occupancy;
    if (cmd.shift_dn_init) ptr <= lo + CNT_W'(1);
    if (cmd.shift_up) begin
      ptr       <= ptr_dec;
      pend_addr <= ptr[ADDR_W-1:0];
    end
    if (cmd.shift_dn) begin
      ptr       <= ptr + CNT_W'(1);
      pend_addr <= ptr_dec[ADDR_W-1:0];
    end
    if (cmd.out_load) begin
      rsp.status       <= res_status;
      rsp.stored_value <= res_value;
      rsp.entry_count  <= COUNT_W'(occupancy);
    end
  end

  always_comb begin
    sts.command   = cur.command;
    sts.cmd_known = (cur.command == CMD_GET) || (cur.command == CMD_PUT) ||
                    (cur.command == CMD_REMOVE);
    sts.in_range  = ((cur.pos_x[31:15] == '0) || (cur.pos_x[31:15] == '1)) &&
                    ((cur.pos_z[31:15] == '0) || (cur.pos_z[31:15] == '1)) &&
                    (cur.pos_y[31:8] == '0);
    sts.lo_lt_hi  = lo < hi;
    sts.lo_lt_occ = lo < occupancy;
    sts.hit       = hit;
    sts.full      = occupancy == DEPTH_CNT;
    sts.up_more   = ptr > lo;
    sts.dn_more   = ptr < occupancy;
    sts.out_busy  = rsp_valid && rsp_stall;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= DEPTH_CNT)
    else $error("occupancy above table depth");

  a_search_window: assert property (@(posedge clk) disable iff (rst)
    cmd.cmp_step |-> (lo < hi) && (hi <= occupancy))
    else $error("search window out of order");

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    pend |-> !(cmd.overwrite || cmd.place))
    else $error("shift copy collides with entry write");

  a_no_full_insert: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> occupancy < DEPTH_CNT)
    else $error("insert into full table");

  a_remove_needs_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_dn_init |-> hit)
    else $error("remove started without a matching entry");

endmodule

@@ hdl/sorted_coordinate_key_value_table.sv @@
// Channel   Direction  Handshake                 Payload
// request   in         req_valid / req_stall     req  (command, pos_x, pos_y, pos_z, new_value)
// response  out        rsp_valid / rsp_stall     rsp  (status, stored_value, entry_count)
//
// A request is accepted, checked and then binary-searched; each probe of the search is a
// registered read followed by a compare step. An insert then shifts the entries above the
// position up and a delete shifts them down, the entries moving one per cycle.
// Reset empties the table at once (count goes to zero); no clearing pass.
// req_stall is high from acceptance until the response is in the output register;
// a stalled response holds in that register while the next request is taken.
module sorted_coordinate_key_value_table (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  sckv_pkg::request_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sckv_pkg::response_t rsp
);
  import sckv_pkg::*;

  // Commands from the sequencer, status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequence check, search, shift and response load.
  sckv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the table memory, search bounds, entry count and output register.
  sckv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
